@@ src/stereo_peak_limiter_macros.svh @@
// ----------------------------------------------------------------------------
// stereo peak limiter assertion macros
// shared wrappers for the concurrent checks on the limiter ports
// ----------------------------------------------------------------------------
`ifndef STEREO_PEAK_LIMITER_MACROS_SVH
`define STEREO_PEAK_LIMITER_MACROS_SVH

// checked only out of reset
`define SPL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SPL_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/spl_pkg.sv @@
// ----------------------------------------------------------------------------
// spl_pkg
// widths, register codes, beat types and sample helpers of the peak limiter
// ----------------------------------------------------------------------------
package spl_pkg;

	localparam int SAMPLE_BITS   = 24;
	localparam int PEAK_BITS     = SAMPLE_BITS - 1;
	localparam int GAIN_BITS     = 24;
	localparam int THR_BITS      = 20;
	localparam int REL_BITS      = 24;
	localparam int STEP_COUNT    = GAIN_BITS;
	localparam int CNT_BITS      = 5;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 24;

	localparam logic [THR_BITS-1:0] THR_RESET = 20'd934567;
	localparam logic [REL_BITS-1:0] REL_RESET = 24'd16773721;
	localparam logic [GAIN_BITS:0]  GAIN_UNITY = {1'b1, {GAIN_BITS{1'b0}}};

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_RELEASE   = 2'd1,
		CFG_STEREO    = 2'd2
	} spl_cfg_idx_t;

	typedef logic signed [SAMPLE_BITS-1:0] spl_sample_t;

	typedef struct packed {
		spl_sample_t in_left;
		spl_sample_t in_right;
		logic        block_end;
	} spl_in_t;

	typedef struct packed {
		spl_sample_t          out_left;
		spl_sample_t          out_right;
		logic [GAIN_BITS:0]   applied_gain;
		logic                 limiting;
		logic                 block_end_out;
	} spl_out_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} spl_ctl_t;

	// magnitude of a two's complement sample, most negative gives 2^(n-1)
	function automatic logic [SAMPLE_BITS-1:0] spl_mag(input spl_sample_t s);
		logic [SAMPLE_BITS-1:0] u;
		begin
			u = s;
			return u[SAMPLE_BITS-1] ? (~u + 1'b1) : u;
		end
	endfunction

	function automatic spl_sample_t spl_apply_sign(input logic [SAMPLE_BITS-1:0] m,
		input logic neg);
		logic [SAMPLE_BITS-1:0] r;
		begin
			r = neg ? (~m + 1'b1) : m;
			return spl_sample_t'(r);
		end
	endfunction

endpackage

@@ src/spl_env.sv @@
// ----------------------------------------------------------------------------
// spl_env
// frame peak and envelope with instant attack and bit-serial release multiply
// ----------------------------------------------------------------------------
module spl_env (
	input  logic                         clk,
	input  logic                         arst_n,
	input  spl_pkg::spl_ctl_t            ctl,
	input  spl_pkg::spl_in_t             beat,
	input  logic                         stereo_mode,
	input  logic [spl_pkg::REL_BITS-1:0] release_factor,
	output logic [spl_pkg::PEAK_BITS-1:0] env_next
);
	import spl_pkg::*;

	logic [SAMPLE_BITS-1:0] mag_l;
	logic [SAMPLE_BITS-1:0] mag_r;
	logic [SAMPLE_BITS-1:0] mag_max;
	logic [PEAK_BITS-1:0]   peak;
	logic [PEAK_BITS:0]     sum;

	logic [PEAK_BITS-1:0] env_q;
	logic [PEAK_BITS-1:0] peak_q;
	logic [PEAK_BITS-1:0] diff_q;
	logic [PEAK_BITS-1:0] acc_q;
	logic [REL_BITS-1:0]  rf_q;
	logic                 attack_q;

	always_comb begin
		mag_l   = spl_mag(beat.in_left);
		mag_r   = stereo_mode ? spl_mag(beat.in_right) : '0;
		mag_max = (mag_r > mag_l) ? mag_r : mag_l;
		// saturate the most negative sample
		peak    = mag_max[SAMPLE_BITS-1] ? '1 : mag_max[PEAK_BITS-1:0];
	end

	assign sum      = {1'b0, acc_q} + (rf_q[0] ? {1'b0, diff_q} : '0);
	assign env_next = attack_q ? peak_q : peak_q + acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= '0;
		end else if (ctl.finish) begin
			env_q <= env_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			peak_q   <= peak;
			attack_q <= peak > env_q;
			diff_q   <= env_q - peak;
			acc_q    <= '0;
			rf_q     <= release_factor;
		end else if (ctl.step) begin
			acc_q <= sum[PEAK_BITS:1];
			rf_q  <= rf_q >> 1;
		end
	end

endmodule

@@ src/spl_div.sv @@
// ----------------------------------------------------------------------------
// spl_div
// restoring divider, one quotient bit per cycle, for threshold over envelope
// ----------------------------------------------------------------------------
module spl_div (
	input  logic                          clk,
	input  spl_pkg::spl_ctl_t             ctl,
	input  logic [spl_pkg::THR_BITS-1:0]  threshold,
	input  logic [spl_pkg::PEAK_BITS-1:0] envelope,
	output logic [spl_pkg::GAIN_BITS:0]   gain,
	output logic                          limiting
);
	import spl_pkg::*;

	logic [PEAK_BITS-1:0] thr_ext;
	logic [PEAK_BITS:0]   trial;
	logic [PEAK_BITS:0]   rest;
	logic                 fits;

	logic [PEAK_BITS-1:0] rem_q;
	logic [PEAK_BITS-1:0] den_q;
	logic [GAIN_BITS-1:0] quo_q;
	logic                 limit_q;

	assign thr_ext = {{(PEAK_BITS-THR_BITS){1'b0}}, threshold};
	assign trial   = {rem_q, 1'b0};
	assign fits    = trial >= {1'b0, den_q};
	assign rest    = trial - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			// quotient bits above the binary point are zero, remainder is the threshold
			rem_q   <= thr_ext;
			den_q   <= envelope;
			quo_q   <= '0;
			limit_q <= envelope > thr_ext;
		end else if (ctl.step) begin
			rem_q <= fits ? rest[PEAK_BITS-1:0] : trial[PEAK_BITS-1:0];
			quo_q <= {quo_q[GAIN_BITS-2:0], fits};
		end
	end

	assign gain     = limit_q ? {1'b0, quo_q} : GAIN_UNITY;
	assign limiting = limit_q;

endmodule

@@ src/spl_scaler.sv @@
// ----------------------------------------------------------------------------
// spl_scaler
// two bit-serial lanes scaling the left and right magnitudes by the gain
// ----------------------------------------------------------------------------
module spl_scaler (
	input  logic                        clk,
	input  spl_pkg::spl_ctl_t           ctl,
	input  spl_pkg::spl_in_t            beat,
	input  logic                        stereo_mode,
	input  logic [spl_pkg::GAIN_BITS:0] gain,
	output spl_pkg::spl_sample_t        out_left,
	output spl_pkg::spl_sample_t        out_right
);
	import spl_pkg::*;

	logic [SAMPLE_BITS:0]   sum_l;
	logic [SAMPLE_BITS:0]   sum_r;
	logic [SAMPLE_BITS-1:0] res_l;
	logic [SAMPLE_BITS-1:0] res_r;

	logic [SAMPLE_BITS-1:0] mag_l_q;
	logic [SAMPLE_BITS-1:0] mag_r_q;
	logic [SAMPLE_BITS-1:0] acc_l_q;
	logic [SAMPLE_BITS-1:0] acc_r_q;
	logic [GAIN_BITS-1:0]   g_q;
	logic                   neg_l_q;
	logic                   neg_r_q;
	logic                   unity_q;
	logic                   mono_q;

	assign sum_l = {1'b0, acc_l_q} + (g_q[0] ? {1'b0, mag_l_q} : '0);
	assign sum_r = {1'b0, acc_r_q} + (g_q[0] ? {1'b0, mag_r_q} : '0);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mag_l_q <= spl_mag(beat.in_left);
			mag_r_q <= spl_mag(beat.in_right);
			neg_l_q <= beat.in_left[SAMPLE_BITS-1];
			neg_r_q <= beat.in_right[SAMPLE_BITS-1];
			acc_l_q <= '0;
			acc_r_q <= '0;
			g_q     <= gain[GAIN_BITS-1:0];
			unity_q <= gain[GAIN_BITS];
			mono_q  <= !stereo_mode;
		end else if (ctl.step) begin
			acc_l_q <= sum_l[SAMPLE_BITS:1];
			acc_r_q <= sum_r[SAMPLE_BITS:1];
			g_q     <= g_q >> 1;
		end
	end

	// unity gain passes the magnitude straight through
	assign res_l     = unity_q ? mag_l_q : acc_l_q;
	assign res_r     = unity_q ? mag_r_q : acc_r_q;
	assign out_left  = spl_apply_sign(res_l, neg_l_q);
	assign out_right = mono_q ? '0 : spl_apply_sign(res_r, neg_r_q);

endmodule

@@ src/stereo_peak_limiter.sv @@
// ----------------------------------------------------------------------------
// stereo_peak_limiter: peak limiter, instant attack, exponential release
// each frame runs three 24-step bit-serial passes: release multiply, divide,
// scale; input beats stall until the output register takes the result
// async reset: envelope zero, registers to defaults, no output beat pending
// ----------------------------------------------------------------------------
module stereo_peak_limiter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [spl_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [spl_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  spl_pkg::spl_in_t                  in_beat,
	output logic                              out_valid,
	input  logic                              out_stall,
	output spl_pkg::spl_out_t                 out_beat
);
	import spl_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_ENV_LD = 8'b0000_0010,
		ST_ENV    = 8'b0000_0100,
		ST_DIV_LD = 8'b0000_1000,
		ST_DIV    = 8'b0001_0000,
		ST_SC_LD  = 8'b0010_0000,
		ST_SC     = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} spl_state_t;

	spl_state_t          state_q;
	spl_state_t          state_nxt;
	logic [CNT_BITS-1:0] cnt_q;
	logic                last_step;
	logic                in_fire;
	logic                out_load;

	logic [THR_BITS-1:0] thr_q;
	logic [REL_BITS-1:0] rel_q;
	logic                stereo_q;
	spl_in_t             in_q;
	spl_out_t            out_q;
	logic                out_valid_q;

	spl_ctl_t             env_ctl;
	spl_ctl_t             div_ctl;
	spl_ctl_t             sc_ctl;
	logic [PEAK_BITS-1:0] envelope;
	logic [GAIN_BITS:0]   gain;
	logic                 limiting;
	spl_sample_t          res_left;
	spl_sample_t          res_right;

	assign in_stall  = state_q != ST_IDLE;
	assign in_fire   = in_valid && !in_stall;
	assign last_step = cnt_q == CNT_BITS'(STEP_COUNT - 1);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RESET;
			rel_q    <= REL_RESET;
			stereo_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_THRESHOLD: thr_q    <= cfg_data[THR_BITS-1:0];
				CFG_RELEASE:   rel_q    <= cfg_data[REL_BITS-1:0];
				CFG_STEREO:    stereo_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_fire) state_nxt = ST_ENV_LD;
			ST_ENV_LD: state_nxt = ST_ENV;
			ST_ENV:    if (last_step) state_nxt = ST_DIV_LD;
			ST_DIV_LD: state_nxt = ST_DIV;
			ST_DIV:    if (last_step) state_nxt = ST_SC_LD;
			ST_SC_LD:  state_nxt = ST_SC;
			ST_SC:     if (last_step) state_nxt = ST_DONE;
			ST_DONE:   if (out_load) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (env_ctl.step || div_ctl.step || sc_ctl.step) begin
				cnt_q <= last_step ? '0 : cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		env_ctl.load   = state_q == ST_ENV_LD;
		env_ctl.step   = state_q == ST_ENV;
		env_ctl.finish = state_q == ST_DIV_LD;
		div_ctl.load   = state_q == ST_DIV_LD;
		div_ctl.step   = state_q == ST_DIV;
		div_ctl.finish = 1'b0;
		sc_ctl.load    = state_q == ST_SC_LD;
		sc_ctl.step    = state_q == ST_SC;
		sc_ctl.finish  = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			in_q <= in_beat;
		end
	end

	spl_env u_env (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (env_ctl),
		.beat           (in_q),
		.stereo_mode    (stereo_q),
		.release_factor (rel_q),
		.env_next       (envelope)
	);

	spl_div u_div (
		.clk       (clk),
		.ctl       (div_ctl),
		.threshold (thr_q),
		.envelope  (envelope),
		.gain      (gain),
		.limiting  (limiting)
	);

	spl_scaler u_scaler (
		.clk         (clk),
		.ctl         (sc_ctl),
		.beat        (in_q),
		.stereo_mode (stereo_q),
		.gain        (gain),
		.out_left    (res_left),
		.out_right   (res_right)
	);

	// output register lets the next frame start while this beat waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.out_left      <= res_left;
			out_q.out_right     <= res_right;
			out_q.applied_gain  <= gain;
			out_q.limiting      <= limiting;
			out_q.block_end_out <= in_q.block_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

endmodule

@@ src/spl_checker.sv @@
// ----------------------------------------------------------------------------
// spl_checker
// port-level checks on the limiter, bound to the top level
// ----------------------------------------------------------------------------
`include "stereo_peak_limiter_macros.svh"

module spl_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input spl_pkg::spl_out_t out_beat
);
	import spl_pkg::*;

	logic unity_ok;
	logic limit_ok;

	assign unity_ok = out_beat.limiting || (out_beat.applied_gain == GAIN_UNITY);
	assign limit_ok = !out_beat.limiting || !out_beat.applied_gain[GAIN_BITS];

	`SPL_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_beat), "beat changed")
	`SPL_ASSERT(a_busy_after_in, in_valid && !in_stall |=> in_stall, "second frame taken while busy")
	`SPL_ASSERT(a_unity_gain, out_valid |-> unity_ok, "unlimited frame without unity gain")
	`SPL_ASSERT(a_limit_gain, out_valid |-> limit_ok, "limited frame at or above unity gain")
	`SPL_ASSERT_RST(a_reset_quiet, !arst_n |=> !out_valid, "output beat during reset")

endmodule

bind stereo_peak_limiter spl_checker u_spl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_beat  (out_beat)
);

@@ bench/stereo_peak_limiter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_peak_limiter_test
// drives audio frames through the limiter under random idling and back
// pressure, predicts each limited frame from its own envelope and gain
// arithmetic, and checks every output beat field by field, in order
// ----------------------------------------------------------------------------
module stereo_peak_limiter_test;

	import spl_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
	localparam logic [SAMPLE_BITS-1:0]  PEAK_MAX  = {1'b0, {PEAK_BITS{1'b1}}};
	localparam int                      THR_LOW   = 525600;
	localparam int                      THR_HIGH  = 1036643;
	localparam int                      QUIET_LIMIT = 4000;
	localparam int                      DRAIN_CYCLES = 100;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	spl_in_t     in_beat = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	spl_out_t    out_beat;

	// limiter state and registers as the bench sees them
	logic [PEAK_BITS-1:0] envelope;
	logic [THR_BITS-1:0]  thr_level;
	logic [REL_BITS-1:0]  rel_factor;
	logic                 stereo_on;

	spl_in_t  frame_queue[$];
	spl_out_t limited_frames[$];
	spl_out_t want;

	int idle_pct = 18;
	int mismatches = 0;
	int frames_in = 0;
	int frames_out = 0;
	int limited_count = 0;
	int mono_count = 0;
	int cfg_writes = 0;
	int quiet_cycles = 0;

	stereo_peak_limiter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_beat   (in_beat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

	always #2 clk = ~clk;

	function automatic logic [SAMPLE_BITS-1:0] magnitude(input spl_sample_t s);
		logic [SAMPLE_BITS-1:0] u;
		u = s;
		if (u[SAMPLE_BITS-1]) begin
			u = (~u) + 1'b1;
		end
		return u;
	endfunction

	function automatic spl_sample_t scaled(input spl_sample_t s, input logic [GAIN_BITS:0] g);
		logic [63:0] prod;
		logic [SAMPLE_BITS-1:0] r;
		prod = 64'(magnitude(s)) * 64'(g);
		prod = prod >> GAIN_BITS;
		r = prod[SAMPLE_BITS-1:0];
		if (s[SAMPLE_BITS-1]) begin
			r = (~r) + 1'b1;
		end
		return spl_sample_t'(r);
	endfunction

	function automatic spl_out_t limit_frame(input spl_in_t f);
		logic [SAMPLE_BITS-1:0] peak;
		logic [SAMPLE_BITS-1:0] mag_r;
		logic [63:0] decay;
		logic [63:0] ratio;
		spl_out_t res;
		peak = magnitude(f.in_left);
		mag_r = magnitude(f.in_right);
		if (stereo_on && mag_r > peak) begin
			peak = mag_r;
		end
		if (peak > PEAK_MAX) begin
			peak = PEAK_MAX;
		end
		// instant attack, otherwise decay toward the peak
		if (peak > envelope) begin
			envelope = peak[PEAK_BITS-1:0];
		end else begin
			decay = 64'(envelope - peak[PEAK_BITS-1:0]) * 64'(rel_factor);
			decay = decay >> REL_BITS;
			envelope = peak[PEAK_BITS-1:0] + decay[PEAK_BITS-1:0];
		end
		res.limiting = (envelope > thr_level);
		if (res.limiting) begin
			ratio = (64'(thr_level) << GAIN_BITS) / 64'(envelope);
			res.applied_gain = ratio[GAIN_BITS:0];
		end else begin
			res.applied_gain = GAIN_UNITY;
		end
		res.out_left = scaled(f.in_left, res.applied_gain);
		res.out_right = stereo_on ? scaled(f.in_right, res.applied_gain) : spl_sample_t'(0);
		res.block_end_out = f.block_end;
		if (!stereo_on) begin
			mono_count++;
		end
		return res;
	endfunction

	function automatic spl_sample_t random_sample(input int cls);
		logic [SAMPLE_BITS-1:0] v;
		case (cls)
			0: begin
				case ($urandom_range(4))
					0: v = 24'h7FFFFF;
					1: v = 24'h800000;
					2: v = 24'h000000;
					3: v = 24'hFFFFFF;
					default: v = 24'h000001;
				endcase
				return spl_sample_t'(v);
			end
			1: begin
				v = SAMPLE_BITS'($urandom());
				return spl_sample_t'(v);
			end
			2: v = SAMPLE_BITS'($urandom_range(0, 1 << 19));
			3: v = SAMPLE_BITS'($urandom_range(850000, 1100000));
			default: v = SAMPLE_BITS'($urandom_range(1100000, 8388607));
		endcase
		if ($urandom_range(1)) begin
			v = (~v) + 1'b1;
		end
		return spl_sample_t'(v);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] exp_val);
		$display("%0t mismatch on beat %0d: %s got %0h expected %0h",
			$realtime, frames_out, what, got, exp_val);
		mismatches++;
	endtask

	task automatic set_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_THRESHOLD: thr_level = data[THR_BITS-1:0];
			CFG_RELEASE: rel_factor = data[REL_BITS-1:0];
			CFG_STEREO: stereo_on = data[0];
			default: ;
		endcase
		cfg_writes++;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic push(input spl_sample_t l, input spl_sample_t r, input logic be);
		spl_in_t f;
		f.in_left = l;
		f.in_right = r;
		f.block_end = be;
		frame_queue.insert(frame_queue.size(), f);
	endtask

	task automatic wait_drained;
		@(negedge clk);
		while (frame_queue.size() != 0 || in_valid || limited_frames.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// input side: one beat held until taken, prediction at acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_beat <= '0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				limited_frames.insert(limited_frames.size(), limit_frame(in_beat));
				frames_in++;
			end
			if (frame_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
				in_valid <= 1'b1;
				in_beat <= frame_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side: random back pressure and in-order checking
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < idle_pct);
			if (out_valid && !out_stall) begin
				frames_out++;
				if (limited_frames.size() == 0) begin
					report_mismatch("beat with nothing expected, gain",
						64'(out_beat.applied_gain), 64'(0));
				end else begin
					want = limited_frames.pop_front();
					if (want.limiting) begin
						limited_count++;
					end
					if (out_beat.out_left !== want.out_left)
						report_mismatch("out_left", 64'(out_beat.out_left),
							64'(want.out_left));
					if (out_beat.out_right !== want.out_right)
						report_mismatch("out_right", 64'(out_beat.out_right),
							64'(want.out_right));
					if (out_beat.applied_gain !== want.applied_gain)
						report_mismatch("applied_gain", 64'(out_beat.applied_gain),
							64'(want.applied_gain));
					if (out_beat.limiting !== want.limiting)
						report_mismatch("limiting", 64'(out_beat.limiting),
							64'(want.limiting));
					if (out_beat.block_end_out !== want.block_end_out)
						report_mismatch("block_end_out", 64'(out_beat.block_end_out),
							64'(want.block_end_out));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no beat for %0d cycles", quiet_cycles);
				$display("stereo_peak_limiter test failed");
				$finish;
			end
		end
	end

	initial begin
		int cls;
		int run_left;
		int pick;
		logic [CFG_DATA_BITS-1:0] data;

		envelope = '0;
		thr_level = THR_RESET;
		rel_factor = REL_RESET;
		stereo_on = 1'b1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, linked stereo
		push(24'sh000000, 24'sh000000, 1'b0);
		push(24'sh000001, -24'sh000001, 1'b0);
		push(24'sh7FFFFF, 24'sh000000, 1'b0);
		push(24'sh000000, 24'sh800000, 1'b1);
		push(24'sh800000, 24'sh7FFFFF, 1'b0);
		push(24'sh080000, -24'sh080000, 1'b0);
		push(24'sh000000, 24'sh000000, 1'b1);
		push(-24'sh0E4000, 24'sh0E4000, 1'b0);
		push(24'shFFFFFF, 24'sh000001, 1'b0);
		push(24'sh555555, 24'shAAAAAA, 1'b0);
		wait_drained;

		// mono, right ignored
		set_reg(CFG_STEREO, 24'd0);
		push(24'sh100000, 24'sh7FFFFF, 1'b0);
		push(24'sh800000, 24'sh800000, 1'b1);
		push(24'sh020000, -24'sh7FFFFF, 1'b0);
		push(24'sh7FFFFF, 24'sh000000, 1'b0);
		wait_drained;

		// zero threshold and zero release
		set_reg(CFG_THRESHOLD, 24'd0);
		set_reg(CFG_RELEASE, 24'd0);
		set_reg(CFG_STEREO, 24'd1);
		push(24'sh000000, 24'sh000000, 1'b0);
		push(24'sh000001, 24'sh000000, 1'b0);
		push(24'sh7FFFFF, 24'sh800000, 1'b0);
		push(24'sh000010, 24'sh000000, 1'b1);
		push(24'sh000000, 24'sh000000, 1'b0);
		wait_drained;

		// spare index ignored, wide data masked to the register width
		set_reg(CFG_SPARE, 24'hFFFFFF);
		set_reg(CFG_THRESHOLD, 24'hFFFFFF);
		set_reg(CFG_RELEASE, 24'hFFFFFF);
		set_reg(CFG_STEREO, 24'hFFFFFF);
		push(24'sh7FFFFF, 24'sh123456, 1'b0);
		push(24'sh000000, 24'sh000000, 1'b0);
		push(24'sh0FFFFF, -24'sh100000, 1'b1);
		push(24'sh100001, 24'sh000000, 1'b0);
		wait_drained;

		set_reg(CFG_THRESHOLD, 24'(THR_LOW));
		set_reg(CFG_RELEASE, REL_RESET);
		push(24'sh090000, 24'sh000000, 1'b0);
		push(-24'sh080000, 24'sh07FFFF, 1'b0);
		wait_drained;

		// random phases: bursts of one kind of material so the envelope
		// both attacks and releases over many frames
		for (int phase = 0; phase < 9; phase++) begin
			idle_pct = (phase == 4) ? 0 : 18;
			case ($urandom_range(5))
				0: data = 24'(THR_LOW);
				1: data = 24'(THR_HIGH);
				2, 3: data = 24'($urandom_range(THR_LOW, THR_HIGH));
				4: data = 24'($urandom_range(0, (1 << THR_BITS) - 1));
				default: data = 24'($urandom());
			endcase
			set_reg(CFG_THRESHOLD, data);
			case ($urandom_range(4))
				0: data = 24'd0;
				1: data = 24'hFFFFFF;
				2: data = 24'($urandom_range(16000000, 16777215));
				3: data = 24'($urandom());
				default: data = REL_RESET;
			endcase
			set_reg(CFG_RELEASE, data);
			data = 24'($urandom()) & 24'hFFFFFE;
			data[0] = ($urandom_range(3) != 0);
			set_reg(CFG_STEREO, data);
			if ($urandom_range(2) == 0) begin
				set_reg(CFG_SPARE, 24'($urandom()));
			end
			run_left = 0;
			cls = 1;
			for (int n = 0; n < 55; n++) begin
				if (run_left == 0) begin
					run_left = $urandom_range(1, 16);
					pick = $urandom_range(99);
					if (pick < 8) begin
						cls = 0;
					end else if (pick < 40) begin
						cls = 1;
					end else if (pick < 65) begin
						cls = 2;
					end else if (pick < 82) begin
						cls = 3;
					end else begin
						cls = 4;
					end
				end
				run_left--;
				push(random_sample(cls), random_sample(cls), ($urandom_range(15) == 0));
			end
			wait_drained;
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d frames in, %0d checked, %0d limiting, %0d in mono",
			frames_in, frames_out, limited_count, mono_count);
		$display("%0d register writes over 14 settings, %0d mismatches",
			cfg_writes, mismatches);
		if (mismatches == 0) begin
			$display("stereo_peak_limiter test passed");
		end else begin
			$display("stereo_peak_limiter test failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+src
src/spl_pkg.sv
src/spl_env.sv
src/spl_div.sv
src/spl_scaler.sv
src/stereo_peak_limiter.sv
src/spl_checker.sv
bench/stereo_peak_limiter_test.sv
